// ----- rtl/rms_pkg.sv -----
`timescale 1ns / 1ps
package rms_pkg;
	localparam int MaxRecords   = 64;
	localparam int NameKeyBytes = 8;
	localparam int TagW  = 16;
	localparam int NameW = 64;
	localparam int LonW  = 25;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_INIT,
		ST_PASS,
		ST_FIND,
		ST_RDA,
		ST_CMP,
		ST_COPY,
		ST_BACK_RD,
		ST_BACK,
		ST_OUT_RD,
		ST_OUT_WAIT,
		ST_OUT
	} rms_state_t;
endpackage

// ----- rtl/record_merge_sorter_top.sv -----
`timescale 1ns / 1ps
// Records load one per cycle while busy is low; a word with last_in high starts
// the sort. The sort is a bottom-up merge over widths 1,2,4,.. that reproduces the
// top-down split (left half floor(n/2)): at each width the run covering the next
// position is found by halving from [0,n), one step per cycle. Each merged element
// passes ST_RDA, ST_CMP and ST_COPY through the index memory, then ST_BACK_RD and
// ST_BACK copy the merged run back. The burst then steps through ST_OUT_RD,
// ST_OUT_WAIT and ST_OUT for each result, with out_valid high in ST_OUT; the
// receiver cannot stall it. The key mode written through cfg_we is sampled when
// the last record arrives.
module record_merge_sorter_top import rms_pkg::*; #(
	parameter int MAX_RECORDS = MaxRecords,
	parameter int NAME_KEY_BYTES = NameKeyBytes
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   cfg_we,
	input  logic                   cfg_wdata,
	input  logic [TagW-1:0]        record_tag,
	input  logic [NameW-1:0]       name_key,
	input  logic signed [LonW-1:0] longitude,
	input  logic                   last_in,
	output logic                   out_valid,
	output logic [TagW-1:0]        sorted_tag,
	output logic [NameW-1:0]       sorted_name_key,
	output logic signed [LonW-1:0] sorted_longitude,
	output logic                   last_out,
	output logic                   overflow
);
	localparam int AW = $clog2(MAX_RECORDS);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] MaxCnt = CW'(MAX_RECORDS);
	localparam logic [NameW-1:0] NameMask = {NameW{1'b1}} << (8 * (8 - NAME_KEY_BYTES));

	rms_state_t state_q, state_d;
	logic          mode_q, sort_mode_q, ovf_q;
	logic [CW-1:0] cnt_q;
	// merge bookkeeping
	logic [CW-1:0] width_q, lo_q, mid_q, hi_q, i_q, j_q, k_q;
	logic [CW-1:0] init_q;
	logic [CW-1:0] cp_q, sl_q, sh_q;

	// store ports
	logic          st_we;
	logic [AW-1:0] st_ra, st_rb;
	logic [TagW-1:0]        rtag_a;
	logic [NameW-1:0]       rname_a, rname_b;
	logic signed [LonW-1:0] rlon_a, rlon_b;
	// index ports
	logic          ix_we;
	logic [AW:0]   ix_wa, ix_ra, ix_rb;
	logic [AW-1:0] ix_wd, ix_da, ix_db;

	logic accept;
	assign accept = start && !busy;
	assign busy   = (state_q != ST_LOAD);

	rms_store #(.MAX_RECORDS(MAX_RECORDS)) u_store (
		.clk(clk), .we(st_we), .waddr(cnt_q[AW-1:0]), .wtag(record_tag),
		.wname(name_key), .wlon(longitude), .raddr_a(st_ra), .raddr_b(st_rb),
		.rtag_a(rtag_a), .rname_a(rname_a), .rlon_a(rlon_a),
		.rname_b(rname_b), .rlon_b(rlon_b)
	);

	rms_index #(.MAX_RECORDS(MAX_RECORDS)) u_index (
		.clk(clk), .we(ix_we), .waddr(ix_wa), .wdata(ix_wd),
		.raddr_a(ix_ra), .raddr_b(ix_rb), .rdata_a(ix_da), .rdata_b(ix_db)
	);

	assign st_we = accept && (cnt_q < MaxCnt);

	// run search window [sl,sh) and its floor split point
	logic [CW-1:0] fd_len, fd_mid;
	logic          i_ok, j_ok, take_left, a_less;

	assign fd_len = sh_q - sl_q;
	assign fd_mid = sl_q + (fd_len >> 1);

	assign i_ok = (i_q < mid_q);
	assign j_ok = (j_q < hi_q);
	assign a_less = sort_mode_q ? (rlon_a < rlon_b)
		: ((rname_a & NameMask) < (rname_b & NameMask));
	assign take_left = i_ok && (!j_ok || a_less);

	// state register and data path registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			mode_q  <= 1'b0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) mode_q <= cfg_wdata;
			if (accept) begin
				if (cnt_q < MaxCnt) cnt_q <= cnt_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (state_q == ST_OUT && k_q + 1'b1 == cnt_q) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		ix_we = 1'b0;
		ix_wa = '0;
		ix_wd = '0;
		ix_ra = {1'b0, i_q[AW-1:0]};
		ix_rb = {1'b0, j_q[AW-1:0]};
		st_ra = ix_da;
		st_rb = ix_db;
		unique case (state_q)
			ST_LOAD: begin
				if (accept && last_in) state_d = ST_INIT;
			end
			ST_INIT: begin
				ix_we = 1'b1;
				ix_wa = {1'b0, init_q[AW-1:0]};
				ix_wd = init_q[AW-1:0];
				if (init_q + 1'b1 >= cnt_q) state_d = ST_PASS;
			end
			ST_PASS: begin
				// end of level: finish or go to the next width; else search the next run
				if (lo_q >= cnt_q) begin
					if (width_q >= cnt_q) state_d = ST_OUT_RD;
				end else begin
					state_d = ST_FIND;
				end
			end
			ST_FIND: begin
				// merge only runs first reached at this width
				if (fd_len <= width_q) begin
					if (fd_len < CW'(2) || fd_len <= (width_q >> 1)) state_d = ST_PASS;
					else state_d = ST_RDA;
				end
			end
			ST_RDA: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				// indices are valid; store reads issued now
				state_d = ST_COPY;
			end
			ST_COPY: begin
				ix_we = 1'b1;
				ix_wa = {1'b1, k_q[AW-1:0]};
				ix_wd = take_left ? ix_da : ix_db;
				if (k_q + 1'b1 == hi_q) state_d = ST_BACK_RD;
				else state_d = ST_RDA;
			end
			ST_BACK_RD: begin
				ix_ra = {1'b1, cp_q[AW-1:0]};
				state_d = ST_BACK;
			end
			ST_BACK: begin
				ix_we = 1'b1;
				ix_wa = {1'b0, cp_q[AW-1:0]};
				ix_wd = ix_da;
				if (cp_q + 1'b1 == hi_q) state_d = ST_PASS;
				else state_d = ST_BACK_RD;
			end
			ST_OUT_RD: begin
				ix_ra = {1'b0, k_q[AW-1:0]};
				state_d = ST_OUT_WAIT;
			end
			ST_OUT_WAIT: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (k_q + 1'b1 == cnt_q) state_d = ST_LOAD;
				else state_d = ST_OUT_RD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// merge counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0; width_q <= '0; lo_q <= '0; mid_q <= '0; hi_q <= '0;
			i_q <= '0; j_q <= '0; k_q <= '0; sort_mode_q <= 1'b0;
			cp_q <= '0; sl_q <= '0; sh_q <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					init_q <= '0;
					k_q <= '0;
					if (accept && last_in) begin
						sort_mode_q <= mode_q;
						width_q <= CW'(1);
						lo_q <= '0;
					end
				end
				ST_INIT: init_q <= init_q + 1'b1;
				ST_PASS: begin
					k_q <= '0;
					if (lo_q >= cnt_q) begin
						lo_q <= '0;
						if (width_q < cnt_q) width_q <= width_q << 1;
					end else begin
						sl_q <= '0;
						sh_q <= cnt_q;
					end
				end
				ST_FIND: begin
					// one halving step per cycle toward the run holding lo
					if (fd_len > width_q) begin
						if (lo_q < fd_mid) sh_q <= fd_mid;
						else sl_q <= fd_mid;
					end else if (fd_len < CW'(2) || fd_len <= (width_q >> 1)) begin
						lo_q <= sh_q;
					end else begin
						mid_q <= fd_mid;
						hi_q <= sh_q;
						i_q <= sl_q;
						j_q <= fd_mid;
						k_q <= sl_q;
						cp_q <= sl_q;
					end
				end
				ST_COPY: begin
					k_q <= k_q + 1'b1;
					if (take_left) i_q <= i_q + 1'b1;
					else if (j_ok) j_q <= j_q + 1'b1;
					if (k_q + 1'b1 == hi_q) lo_q <= hi_q;
				end
				ST_BACK: cp_q <= cp_q + 1'b1;
				ST_OUT: k_q <= k_q + 1'b1;
				default: ;
			endcase
		end
	end

	assign out_valid        = (state_q == ST_OUT);
	assign sorted_tag       = rtag_a;
	assign sorted_name_key  = rname_a;
	assign sorted_longitude = rlon_a;
	assign last_out         = out_valid && (k_q + 1'b1 == cnt_q);
	assign overflow         = ovf_q;

	// results only while busy, last only with the strobe
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy);
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_out |-> out_valid);
	// record count never passes capacity
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MaxCnt);
	// every copy step has an element left to take
	a_copy_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY) |-> (i_ok || j_ok));
	// output index stays inside the stored set
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (k_q < cnt_q));
endmodule

// ----- rtl/rms_store.sv -----
`timescale 1ns / 1ps
// record memory: one write port, two registered read ports
module rms_store import rms_pkg::*; #(
	parameter int MAX_RECORDS = MaxRecords,
	localparam int AW = $clog2(MAX_RECORDS)
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic [TagW-1:0]         wtag,
	input  logic [NameW-1:0]        wname,
	input  logic signed [LonW-1:0]  wlon,
	input  logic [AW-1:0]           raddr_a,
	input  logic [AW-1:0]           raddr_b,
	output logic [TagW-1:0]         rtag_a,
	output logic [NameW-1:0]        rname_a,
	output logic signed [LonW-1:0]  rlon_a,
	output logic [NameW-1:0]        rname_b,
	output logic signed [LonW-1:0]  rlon_b
);
	logic [TagW-1:0]        tag_mem [MAX_RECORDS];
	logic [NameW-1:0]       name_mem [MAX_RECORDS];
	logic signed [LonW-1:0] lon_mem [MAX_RECORDS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			tag_mem[waddr]  <= wtag;
			name_mem[waddr] <= wname;
			lon_mem[waddr]  <= wlon;
		end
	end

	// read ports
	always_ff @(posedge clk) begin
		rtag_a  <= tag_mem[raddr_a];
		rname_a <= name_mem[raddr_a];
		rlon_a  <= lon_mem[raddr_a];
		rname_b <= name_mem[raddr_b];
		rlon_b  <= lon_mem[raddr_b];
	end
endmodule

// ----- rtl/rms_index.sv -----
`timescale 1ns / 1ps
// index memory holding the permutation and the merge buffer
module rms_index import rms_pkg::*; #(
	parameter int MAX_RECORDS = MaxRecords,
	localparam int AW = $clog2(MAX_RECORDS)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW:0]   waddr,
	input  logic [AW-1:0] wdata,
	input  logic [AW:0]   raddr_a,
	input  logic [AW:0]   raddr_b,
	output logic [AW-1:0] rdata_a,
	output logic [AW-1:0] rdata_b
);
	// lower half is the scratch permutation, upper half the merge buffer
	logic [AW-1:0] idx_mem [2*MAX_RECORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			idx_mem[waddr] <= wdata;
		end
		rdata_a <= idx_mem[raddr_a];
		rdata_b <= idx_mem[raddr_b];
	end
endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import rms_pkg::*;

	typedef struct {
		logic [TagW-1:0]        tag;
		logic [NameW-1:0]       name;
		logic signed [LonW-1:0] lon;
	} record_t;

	typedef struct {
		logic [TagW-1:0]        tag;
		logic [NameW-1:0]       name;
		logic signed [LonW-1:0] lon;
		logic                   last;
		logic                   ovf;
	} sorted_word_t;

	localparam int LonMax = 11796480;

	// record set predictor and store of expected sorted words
	class sort_scoreboard;
		record_t      recs[$];
		bit           dropped;
		bit           by_lon;
		sorted_word_t pending_words[$];
		int           errors;
		int           checked;
		int           bursts;

		function bit orders_before(record_t x, record_t y);
			logic [NameW-1:0] mask;
			mask = ~64'd0 << (8 * (8 - NameKeyBytes));
			if (by_lon)
				return x.lon < y.lon;
			return (x.name & mask) < (y.name & mask);
		endfunction

		function void merge_sort(ref record_t a[$]);
			record_t lo[$];
			record_t hi[$];
			record_t merged[$];
			int half;
			if (a.size() < 2)
				return;
			half = a.size() / 2;
			lo = a[0:half-1];
			hi = a[half:$];
			merge_sort(lo);
			merge_sort(hi);
			while (lo.size() > 0 && hi.size() > 0) begin
				// strict compare, so ties take the right half first
				if (orders_before(lo[0], hi[0]))
					merged.push_back(lo.pop_front());
				else
					merged.push_back(hi.pop_front());
			end
			while (lo.size() > 0)
				merged.push_back(lo.pop_front());
			while (hi.size() > 0)
				merged.push_back(hi.pop_front());
			a = merged;
		endfunction

		function void note_record(record_t r, bit last, bit mode);
			sorted_word_t w;
			if (recs.size() < MaxRecords)
				recs.push_back(r);
			else
				dropped = 1;
			if (!last)
				return;
			by_lon = mode;
			merge_sort(recs);
			foreach (recs[k]) begin
				w.tag = recs[k].tag;
				w.name = recs[k].name;
				w.lon = recs[k].lon;
				w.last = (k == recs.size() - 1);
				w.ovf = dropped;
				pending_words.push_back(w);
			end
			recs.delete();
			dropped = 0;
			bursts++;
		endfunction

		function void check_word(sorted_word_t got);
			sorted_word_t e;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word tag=%h", $time, got.tag);
				errors++;
				return;
			end
			e = pending_words.pop_front();
			checked++;
			if (got.tag !== e.tag) begin
				$display("%0t: tag exp %h got %h", $time, e.tag, got.tag);
				errors++;
			end
			if (got.name !== e.name) begin
				$display("%0t: name exp %h got %h", $time, e.name, got.name);
				errors++;
			end
			if (got.lon !== e.lon) begin
				$display("%0t: lon exp %0d got %0d", $time, e.lon, got.lon);
				errors++;
			end
			if (got.last !== e.last) begin
				$display("%0t: last exp %b got %b", $time, e.last, got.last);
				errors++;
			end
			if (got.ovf !== e.ovf) begin
				$display("%0t: overflow exp %b got %b", $time, e.ovf, got.ovf);
				errors++;
			end
		endfunction
	endclass

	logic                   clk = 0;
	logic                   arst_n = 0;
	logic                   start = 0;
	logic                   busy;
	logic                   cfg_we = 0;
	logic                   cfg_wdata = 0;
	logic [TagW-1:0]        record_tag = '0;
	logic [NameW-1:0]       name_key = '0;
	logic signed [LonW-1:0] longitude = '0;
	logic                   last_in = 0;
	logic                   out_valid;
	logic [TagW-1:0]        sorted_tag;
	logic [NameW-1:0]       sorted_name_key;
	logic signed [LonW-1:0] sorted_longitude;
	logic                   last_out;
	logic                   overflow;

	sort_scoreboard sb = new();
	bit             mode_now;
	int             idle_cycles;
	int             words_sent;

	record_merge_sorter_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.record_tag(record_tag), .name_key(name_key), .longitude(longitude),
		.last_in(last_in), .out_valid(out_valid), .sorted_tag(sorted_tag),
		.sorted_name_key(sorted_name_key), .sorted_longitude(sorted_longitude),
		.last_out(last_out), .overflow(overflow)
	);

	always #10 clk = ~clk;

	// sample input acceptance and results at the rising edge
	always @(posedge clk) begin
		sorted_word_t got;
		record_t      r;
		bit           seen;
		if (arst_n) begin
			seen = 0;
			if (start && !busy) begin
				r.tag = record_tag;
				r.name = name_key;
				r.lon = longitude;
				sb.note_record(r, last_in, mode_now);
				seen = 1;
			end
			if (out_valid) begin
				got.tag = sorted_tag;
				got.name = sorted_name_key;
				got.lon = sorted_longitude;
				got.last = last_out;
				got.ovf = overflow;
				sb.check_word(got);
				seen = 1;
			end
			idle_cycles <= seen ? 0 : idle_cycles + 1;
		end
	end

	// watchdog: fails the run once idle_cycles passes its limit
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if (idle_cycles > 50000) begin
				$display("watchdog expired");
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	task automatic gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			n = 0;
		if (n > 0)
			start <= 0;
		repeat (n) @(negedge clk);
	endtask

	// drive one record and wait until it is taken
	task automatic send_word(logic [TagW-1:0] t, logic [NameW-1:0] nm,
			logic signed [LonW-1:0] ln, logic lst);
		record_tag <= t;
		name_key <= nm;
		longitude <= ln;
		last_in <= lst;
		start <= 1;
		while (busy)
			@(negedge clk);
		@(posedge clk);
		@(negedge clk);
		words_sent++;
		gap();
	endtask

	task automatic wait_drained();
		start <= 0;
		while (sb.pending_words.size() > 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_mode(bit m);
		wait_drained();
		cfg_wdata <= m;
		cfg_we <= 1;
		@(negedge clk);
		cfg_we <= 0;
		mode_now = m;
	endtask

	function automatic logic signed [LonW-1:0] rand_lon();
		return LonW'($signed($urandom_range(0, 2 * LonMax)) - LonMax);
	endfunction

	// random name key, often with shared prefixes to force ties
	function automatic logic [NameW-1:0] rand_name(bit few);
		if (few)
			return {$urandom_range(0, 3), 32'd0} << 24;
		return {$urandom(), $urandom()};
	endfunction

	task automatic send_set(int n, bit dup);
		for (int k = 0; k < n; k++)
			send_word(TagW'($urandom()), rand_name(dup),
				dup ? LonW'($signed($urandom_range(0, 3)) - 1) : rand_lon(),
				k == n - 1);
	endtask

	initial begin
		int n;
		words_sent = 0;
		mode_now = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: single record, field extremes, ties, both modes
		write_mode(0);
		send_word(16'hffff, '1, LonW'(LonMax), 1'b1);
		send_word(16'h0000, '0, -LonW'(LonMax), 1'b0);
		send_word(16'hffff, '1, LonW'(LonMax), 1'b0);
		send_word(16'h1234, '1, '0, 1'b0);
		send_word(16'h5555, 64'h8000_0000_0000_0000, LonW'(-1), 1'b1);
		write_mode(1);
		send_word(16'h0001, '0, LonW'(LonMax), 1'b0);
		send_word(16'h0002, '0, -LonW'(LonMax), 1'b0);
		send_word(16'h0003, '0, '0, 1'b0);
		send_word(16'h0004, '0, '0, 1'b0);
		send_word(16'h0005, '0, LonW'(-1), 1'b1);
		// mode changes during load: only the value at the last record counts
		send_word(16'h0010, 64'h2, LonW'(5), 1'b0);
		write_mode(0);
		send_word(16'h0011, 64'h1, LonW'(9), 1'b1);

		// overflow: 66 records into a 64-entry store
		send_set(66, 0);
		write_mode(1);
		send_set(65, 1);

		// random sets, mostly small, mode sometimes changed between sets
		while (words_sent < 310) begin
			if ($urandom_range(0, 3) == 0)
				write_mode($urandom_range(0, 1));
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 9);
			send_set(n, $urandom_range(0, 2) == 0);
		end

		wait_drained();
		$display("covered %0d records in %0d bursts, %0d sorted words checked",
			words_sent, sb.bursts, sb.checked);
		$display("both key modes, ties, overflow and field extremes exercised");
		if (sb.errors == 0 && sb.pending_words.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/rms_pkg.sv
rtl/rms_store.sv
rtl/rms_index.sv
rtl/record_merge_sorter_top.sv
bench/testbench.sv
